/* rtl/rsbb_pkg.sv */
// rsbb_pkg: widths, fixed-point constants and shared types of the box bounds pipeline
`timescale 1ns / 1ps
`default_nettype none
package rsbb_pkg;

   // fraction bits of the coordinate / scale format and of the quaternion format
   localparam int COORD_FRAC_BITS = 16;
   localparam int QUAT_FRAC_BITS  = 14;

   // field widths
   localparam int EXT_W   = 31;
   localparam int SCALE_W = 24;
   localparam int QUAT_W  = 16;
   localparam int POS_W   = 63;

   // scaled half extent: extent times scale magnitude, fraction dropped
   localparam int PROD_W = EXT_W + SCALE_W;
   localparam int H_W    = PROD_W - COORD_FRAC_BITS;

   // quaternion products and rotation matrix entries
   localparam int SQ_W   = 2 * QUAT_W;
   localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
   localparam int MAG_W  = (SHIFT + 1 > SQ_W + 1) ? SHIFT + 1 : SQ_W + 1;
   localparam int SGN_W  = MAG_W + 1;

   // split of the scaled extent for the matrix multiply
   localparam int HLO_W  = (H_W + 1) / 2;
   localparam int HHI_W  = H_W - HLO_W;
   localparam int TERM_W = MAG_W + H_W;
   localparam int ACC_W  = TERM_W + 2;

   localparam logic [EXT_W-1:0] EXT_MAX = {EXT_W{1'b1}};
   localparam logic signed [SGN_W-1:0] QUAT_ONE = {{(SGN_W-1){1'b0}}, 1'b1} << SHIFT;

   typedef logic [MAG_W-1:0]            mag_type;
   typedef logic [2:0][MAG_W-1:0]       mrow_type;
   typedef logic [2:0][2:0][MAG_W-1:0]  mmat_type;
   typedef logic [2:0][H_W-1:0]         hvec_type;
   typedef logic [EXT_W-1:0]            ext_type;
   typedef logic [POS_W-1:0]            pos_type;

endpackage
`default_nettype wire

/* rtl/rsbb_channels.sv */
// rsbb channels: request and response word interfaces with valid / ready handshake
`timescale 1ns / 1ps
`default_nettype none
interface rsbb_req_if;
   import rsbb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [EXT_W-1:0]          half_extent_x;
   logic [EXT_W-1:0]          half_extent_y;
   logic [EXT_W-1:0]          half_extent_z;
   logic signed [SCALE_W-1:0] scale_x;
   logic signed [SCALE_W-1:0] scale_y;
   logic signed [SCALE_W-1:0] scale_z;
   logic signed [QUAT_W-1:0]  quat_w;
   logic signed [QUAT_W-1:0]  quat_x;
   logic signed [QUAT_W-1:0]  quat_y;
   logic signed [QUAT_W-1:0]  quat_z;
   logic [POS_W-1:0]          translation_packed;

   modport source (
      output valid, half_extent_x, half_extent_y, half_extent_z,
             scale_x, scale_y, scale_z, quat_w, quat_x, quat_y, quat_z,
             translation_packed,
      input  ready
   );
   modport sink (
      input  valid, half_extent_x, half_extent_y, half_extent_z,
             scale_x, scale_y, scale_z, quat_w, quat_x, quat_y, quat_z,
             translation_packed,
      output ready
   );
endinterface

interface rsbb_rsp_if;
   import rsbb_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] center_packed;
   logic [EXT_W-1:0] out_extent_x;
   logic [EXT_W-1:0] out_extent_y;
   logic [EXT_W-1:0] out_extent_z;

   modport source (
      output valid, center_packed, out_extent_x, out_extent_y, out_extent_z,
      input  ready
   );
   modport sink (
      input  valid, center_packed, out_extent_x, out_extent_y, out_extent_z,
      output ready
   );
endinterface
`default_nettype wire

/* rtl/rsbb_front.sv */
// rsbb_front: stages 1-2, scaled half extents and rotation matrix magnitudes
`timescale 1ns / 1ps
`default_nettype none
module rsbb_front (
   input  wire logic                               clock,
   input  wire logic                               enable,
   input  wire logic [rsbb_pkg::EXT_W-1:0]         half_extent_x,
   input  wire logic [rsbb_pkg::EXT_W-1:0]         half_extent_y,
   input  wire logic [rsbb_pkg::EXT_W-1:0]         half_extent_z,
   input  wire logic signed [rsbb_pkg::SCALE_W-1:0] scale_x,
   input  wire logic signed [rsbb_pkg::SCALE_W-1:0] scale_y,
   input  wire logic signed [rsbb_pkg::SCALE_W-1:0] scale_z,
   input  wire logic signed [rsbb_pkg::QUAT_W-1:0] quat_w,
   input  wire logic signed [rsbb_pkg::QUAT_W-1:0] quat_x,
   input  wire logic signed [rsbb_pkg::QUAT_W-1:0] quat_y,
   input  wire logic signed [rsbb_pkg::QUAT_W-1:0] quat_z,
   output rsbb_pkg::mmat_type                      mat,
   output rsbb_pkg::hvec_type                      hvec
);
   import rsbb_pkg::*;

   typedef logic signed [SQ_W-1:0]  sq_type;
   typedef logic signed [SGN_W-1:0] sgn_type;

   function automatic sgn_type dsum(input sq_type a, input sq_type b);
      return (SGN_W'(a) + SGN_W'(b)) <<< 1;
   endfunction

   function automatic sgn_type ddif(input sq_type a, input sq_type b);
      return (SGN_W'(a) - SGN_W'(b)) <<< 1;
   endfunction

   function automatic mag_type mag(input sgn_type v);
      logic [SGN_W-1:0] a;
      a = v[SGN_W-1] ? -v : v;
      return a[MAG_W-1:0];
   endfunction

   // stage 1: extent * |scale| and the nine quaternion products
   logic [SCALE_W-1:0] smag [3];
   logic signed [SCALE_W-1:0] sc [3];
   logic [EXT_W-1:0] ext [3];
   logic [PROD_W-1:0] prod_in [3];
   logic [PROD_W-1:0] prod_ff [3];
   sq_type xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, wx_in, wy_in, wz_in;
   sq_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   assign sc[0]  = scale_x;
   assign sc[1]  = scale_y;
   assign sc[2]  = scale_z;
   assign ext[0] = half_extent_x;
   assign ext[1] = half_extent_y;
   assign ext[2] = half_extent_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // the most negative scale maps to 2^23 as unsigned
         smag[i]    = sc[i][SCALE_W-1] ? SCALE_W'(-sc[i]) : SCALE_W'(sc[i]);
         prod_in[i] = PROD_W'(ext[i]) * PROD_W'(smag[i]);
      end
   end

   assign xx_in = SQ_W'(quat_x) * SQ_W'(quat_x);
   assign yy_in = SQ_W'(quat_y) * SQ_W'(quat_y);
   assign zz_in = SQ_W'(quat_z) * SQ_W'(quat_z);
   assign xy_in = SQ_W'(quat_x) * SQ_W'(quat_y);
   assign xz_in = SQ_W'(quat_x) * SQ_W'(quat_z);
   assign yz_in = SQ_W'(quat_y) * SQ_W'(quat_z);
   assign wx_in = SQ_W'(quat_w) * SQ_W'(quat_x);
   assign wy_in = SQ_W'(quat_w) * SQ_W'(quat_y);
   assign wz_in = SQ_W'(quat_w) * SQ_W'(quat_z);

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
         xy_ff <= xy_in;
         xz_ff <= xz_in;
         yz_ff <= yz_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         wz_ff <= wz_in;
      end
   end

   // stage 2: matrix entry magnitudes and scaled half extents
   mmat_type mat_in, mat_ff;
   hvec_type h_in, h_ff;

   always_comb begin
      mat_in[0][0] = mag(QUAT_ONE - dsum(yy_ff, zz_ff));
      mat_in[0][1] = mag(ddif(xy_ff, wz_ff));
      mat_in[0][2] = mag(dsum(xz_ff, wy_ff));
      mat_in[1][0] = mag(dsum(xy_ff, wz_ff));
      mat_in[1][1] = mag(QUAT_ONE - dsum(xx_ff, zz_ff));
      mat_in[1][2] = mag(ddif(yz_ff, wx_ff));
      mat_in[2][0] = mag(ddif(xz_ff, wy_ff));
      mat_in[2][1] = mag(dsum(yz_ff, wx_ff));
      mat_in[2][2] = mag(QUAT_ONE - dsum(xx_ff, yy_ff));
      for (int i = 0; i < 3; i++) begin
         h_in[i] = prod_ff[i][PROD_W-1:COORD_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mat_ff <= mat_in;
         h_ff   <= h_in;
      end
   end

   assign mat  = mat_ff;
   assign hvec = h_ff;

endmodule
`default_nettype wire

/* rtl/rsbb_row.sv */
// rsbb_row: stages 3-6 for one output axis, |M row| dot |h| with saturation
`timescale 1ns / 1ps
`default_nettype none
module rsbb_row (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire rsbb_pkg::mrow_type mrow,
   input  wire rsbb_pkg::hvec_type hvec,
   output rsbb_pkg::ext_type       extent
);
   import rsbb_pkg::*;

   localparam int LO_W = MAG_W + HLO_W;
   localparam int HI_W = MAG_W + HHI_W;

   // stage 3: partial products on the low and high halves of h
   logic [LO_W-1:0] lo_in [3];
   logic [LO_W-1:0] lo_ff [3];
   logic [HI_W-1:0] hi_in [3];
   logic [HI_W-1:0] hi_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = LO_W'(mrow[j]) * LO_W'(hvec[j][HLO_W-1:0]);
         hi_in[j] = HI_W'(mrow[j]) * HI_W'(hvec[j][H_W-1:HLO_W]);
      end
   end

   // stage 4: full terms
   logic [TERM_W-1:0] term_in [3];
   logic [TERM_W-1:0] term_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = TERM_W'(lo_ff[j]) + (TERM_W'(hi_ff[j]) << HLO_W);
      end
   end

   // stage 5: sum of the three terms
   logic [ACC_W-1:0] acc_in, acc_ff;
   assign acc_in = ACC_W'(term_ff[0]) + ACC_W'(term_ff[1]) + ACC_W'(term_ff[2]);

   // stage 6: drop the matrix fraction and saturate
   ext_type ext_in, ext_ff;
   always_comb begin
      if (acc_ff[ACC_W-1:SHIFT+EXT_W] != '0) begin
         ext_in = EXT_MAX;
      end else begin
         ext_in = acc_ff[SHIFT+EXT_W-1:SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[j]   <= lo_in[j];
            hi_ff[j]   <= hi_in[j];
            term_ff[j] <= term_in[j];
         end
         acc_ff <= acc_in;
         ext_ff <= ext_in;
      end
   end

   assign extent = ext_ff;

endmodule
`default_nettype wire

/* rtl/rotated_scaled_box_bounds.sv */
// rotated_scaled_box_bounds: top level, six-stage pipeline for rotated and scaled box bounds
// Takes one word per cycle while the response side does not stall and returns one word per
// word, in order, from the output register. Stage one forms extent times scale magnitude
// and the quaternion products, stage two the rotation matrix magnitudes, stages three to five
// the split multiply and sums per axis, and stage six the saturated extents, which sits as
// the output register. The whole pipeline holds while a finished word waits on rsp_ch, so
// req_ch.ready follows rsp_ch.ready whenever the output register is full.
`timescale 1ns / 1ps
`default_nettype none
module rotated_scaled_box_bounds (
   input  wire logic    clock,
   input  wire logic    reset,
   rsbb_req_if.sink     req_ch,
   rsbb_rsp_if.source   rsp_ch
);
   import rsbb_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic              advance;
   pos_type           center_ff [STAGES];
   mmat_type          mat;
   hvec_type          hvec;
   ext_type           extent [3];

   assign advance      = !valid_ff[STAGES-1] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign valid_in     = {valid_ff[STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // center rides along untouched
   always_ff @(posedge clock) begin
      if (advance) begin
         center_ff[0] <= req_ch.translation_packed;
         for (int k = 1; k < STAGES; k++) begin
            center_ff[k] <= center_ff[k-1];
         end
      end
   end

   rsbb_front u_front (
      .clock         (clock),
      .enable        (advance),
      .half_extent_x (req_ch.half_extent_x),
      .half_extent_y (req_ch.half_extent_y),
      .half_extent_z (req_ch.half_extent_z),
      .scale_x       (req_ch.scale_x),
      .scale_y       (req_ch.scale_y),
      .scale_z       (req_ch.scale_z),
      .quat_w        (req_ch.quat_w),
      .quat_x        (req_ch.quat_x),
      .quat_y        (req_ch.quat_y),
      .quat_z        (req_ch.quat_z),
      .mat           (mat),
      .hvec          (hvec)
   );

   for (genvar i = 0; i < 3; i++) begin : g_row
      rsbb_row u_row (
         .clock  (clock),
         .enable (advance),
         .mrow   (mat[i]),
         .hvec   (hvec),
         .extent (extent[i])
      );
   end

   assign rsp_ch.valid         = valid_ff[STAGES-1];
   assign rsp_ch.center_packed = center_ff[STAGES-1];
   assign rsp_ch.out_extent_x  = extent[0];
   assign rsp_ch.out_extent_y  = extent[1];
   assign rsp_ch.out_extent_z  = extent[2];

   // valid bits step one stage on each advance
   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff[STAGES-1:1] == $past(valid_ff[STAGES-2:0]))
      else $error("valid bits did not shift on advance");

   // a stall freezes every stage; checked on the valid bits and the output center
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff) && $stable(center_ff[STAGES-1]))
      else $error("pipeline moved during stall");

   // a waiting word blocks new input
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while output word waits");

   // a word taken with the output empty lands in stage one
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> valid_ff[0])
      else $error("accepted word missing from stage one");

endmodule
`default_nettype wire
